// ===== rtl/core/rcfe_pkg.sv =====
package rcfe_pkg;

  // Channel geometry: three 8-bit channels, red in the top lane.
  localparam int unsigned ChanW   = 8;
  localparam int unsigned NumChan = 3;
  localparam int unsigned ChanRed   = 2;
  localparam int unsigned ChanGreen = 1;
  localparam int unsigned ChanBlue  = 0;

  // The quotient of one channel always fits a channel, so the divider
  // needs one restoring step per quotient bit.
  localparam int unsigned DivSteps = ChanW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  // Step count after reset.
  localparam logic [ChanW-1:0] StepsReset = 8'd32;

  // Item kinds.
  localparam logic KindStart = 1'b0;
  localparam logic KindTick  = 1'b1;

  // Fade modes. The fourth code is unused and a start carrying it is dropped.
  localparam logic [1:0] ModeBlend   = 2'd0;
  localparam logic [1:0] ModeFadeIn  = 2'd1;
  localparam logic [1:0] ModeFadeOut = 2'd2;
  localparam logic [1:0] ModeUnused  = 2'd3;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [NumChan-1:0][ChanW-1:0] color_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] fade_mode;
    chan_t      target_red;
    chan_t      target_green;
    chan_t      target_blue;
  } in_item_t;

  typedef struct packed {
    chan_t frame_red;
    chan_t frame_green;
    chan_t frame_blue;
    logic  last_frame;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StMulFrom,
    StMulTo,
    StDivide,
    StWrite
  } rcfe_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;     // load a new fade from the accepted start item
    logic tick;      // latch step count and end flag for this frame
    logic mul_from;  // acc = from * (steps - index)
    logic mul_to;    // num = acc + to * index, seed the divider
    logic div_step;  // one restoring division step in every lane
    logic commit;    // load the output register and advance the fade
  } rcfe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fading;      // a fade is in progress
    logic at_end;      // current index has reached the step count
    logic frame_last;  // frame being built is the final one
  } rcfe_status_t;

endpackage

// ===== rtl/core/rcfe_ctrl.sv =====
module rcfe_ctrl
  import rcfe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_stall_o,
  input  logic         in_kind_i,
  input  logic [1:0]   in_mode_i,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  input  rcfe_status_t status_i,
  output rcfe_cmd_t    cmd_o
);

  rcfe_state_e        state_q, state_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  logic               in_xfer;
  logic               out_free;

  assign in_stall_o  = (state_q != StIdle);
  assign in_xfer     = in_valid_i && (state_q == StIdle);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;

  // State, divider step count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;

    // A waiting result leaves once the receiver takes it.
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          if (in_kind_i == KindStart) begin
            cmd_o.start = (in_mode_i == ModeBlend) || (in_mode_i == ModeFadeIn) ||
                          (in_mode_i == ModeFadeOut);
          end else if (status_i.fading) begin
            cmd_o.tick = 1'b1;
            state_d    = status_i.at_end ? StWrite : StMulFrom;
          end
        end
      end
      StMulFrom: begin
        cmd_o.mul_from = 1'b1;
        state_d        = StMulTo;
      end
      StMulTo: begin
        cmd_o.mul_to = 1'b1;
        cnt_d        = '0;
        state_d      = StDivide;
      end
      StDivide: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = StWrite;
        end
      end
      StWrite: begin
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

// ===== rtl/core/rcfe_datapath.sv =====
module rcfe_datapath
  import rcfe_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  chan_t        cfg_data_i,
  input  in_item_t     in_data_i,
  input  rcfe_cmd_t    cmd_i,
  output rcfe_status_t status_o,
  output out_item_t    out_data_o
);

  // Fade state.
  chan_t  fade_steps_q;
  color_t dominant_q;
  color_t from_q;
  color_t to_q;
  chan_t  step_q;
  logic   fading_q;
  logic   update_dom_q;

  // Per-frame working registers.
  chan_t  steps_q;
  logic   end_q;
  logic [NumChan-1:0][2*ChanW-1:0] acc_q;
  logic [NumChan-1:0][ChanW-1:0]   rem_q;
  logic [NumChan-1:0][ChanW-1:0]   quo_q;

  out_item_t out_q;
  color_t    target;
  color_t    frame;
  chan_t     weight_from;

  assign target = {in_data_i.target_red, in_data_i.target_green, in_data_i.target_blue};

  assign status_o.fading     = fading_q;
  assign status_o.at_end     = (step_q >= fade_steps_q);
  assign status_o.frame_last = end_q;

  // The index is below the step count on any frame that is interpolated.
  assign weight_from = steps_q - step_q;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_steps_q <= StepsReset;
    end else if (cfg_valid_i) begin
      fade_steps_q <= cfg_data_i;
    end
  end

  // Fade state: loaded by a start, advanced by each committed frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dominant_q   <= '0;
      from_q       <= '0;
      to_q         <= '0;
      step_q       <= '0;
      fading_q     <= 1'b0;
      update_dom_q <= 1'b0;
    end else if (cmd_i.start) begin
      unique case (in_data_i.fade_mode)
        ModeBlend: begin
          from_q       <= dominant_q;
          to_q         <= target;
          update_dom_q <= 1'b1;
        end
        ModeFadeIn: begin
          from_q       <= '0;
          to_q         <= target;
          update_dom_q <= 1'b0;
        end
        default: begin
          from_q       <= target;
          to_q         <= '0;
          update_dom_q <= 1'b0;
        end
      endcase
      step_q   <= '0;
      fading_q <= 1'b1;
    end else if (cmd_i.commit) begin
      if (end_q) begin
        fading_q     <= 1'b0;
        update_dom_q <= 1'b0;
        step_q       <= '0;
        if (update_dom_q) begin
          dominant_q <= to_q;
        end
      end else begin
        step_q <= step_q + 1'b1;
      end
    end
  end

  // Step count and end flag are fixed for the frame being built.
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick) begin
      steps_q <= fade_steps_q;
      end_q   <= (step_q >= fade_steps_q);
    end
  end

  // One lane per channel: the mul_from and mul_to steps build
  // from*(steps-index) + to*index, then a restoring divider by steps
  // shifts the quotient into quo_q one bit per cycle.
  for (genvar c = 0; c < NumChan; c++) begin : g_lane
    logic [2*ChanW-1:0] prod_to;
    logic [ChanW:0]     trial;
    logic [ChanW:0]     diff;
    logic               fits;

    assign prod_to = 16'(to_q[c] * step_q);
    assign trial   = {rem_q[c], quo_q[c][ChanW-1]};
    assign diff    = trial - {1'b0, steps_q};
    assign fits    = (trial >= {1'b0, steps_q});

    always_ff @(posedge clk_i) begin
      if (cmd_i.mul_from) begin
        acc_q[c] <= 16'(from_q[c] * weight_from);
      end
      if (cmd_i.mul_to) begin
        // The high byte of the numerator is below the divisor, which
        // keeps the whole quotient within one channel.
        {rem_q[c], quo_q[c]} <= acc_q[c] + prod_to;
      end else if (cmd_i.div_step) begin
        rem_q[c] <= fits ? diff[ChanW-1:0] : trial[ChanW-1:0];
        quo_q[c] <= {quo_q[c][ChanW-2:0], fits};
      end
    end
  end

  // The final frame is the end color exactly; others come from the divider.
  assign frame = end_q ? to_q : color_t'(quo_q);

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q.frame_red   <= frame[ChanRed];
      out_q.frame_green <= frame[ChanGreen];
      out_q.frame_blue  <= frame[ChanBlue];
      out_q.last_frame  <= end_q;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== rtl/core/rgb_color_fade_engine.sv =====
// Linear RGB crossfade engine. A start item (kind 0) loads a target color and
// a fade mode and produces no frame; each tick item (kind 1) during a fade
// produces one frame, fade_steps+1 frames in all, the last one flagged, and
// ticks outside a fade produce nothing. A start is taken without leaving the
// idle state. A tick that interpolates keeps in_stall_o high after its transfer
// through the multiply states, then the states of the bit-per-cycle restoring
// divider that runs in each channel lane, then the write into the output
// register; the final frame of a fade needs no division and goes straight
// to its write. The output register holds a finished frame while the next
// item is taken; a frame that reaches its write while that register still
// holds an untaken result waits there, with the input stalled, until the
// receiver takes it.
// fade_steps may be written only while the block is idle.
module rgb_color_fade_engine
  import rcfe_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  chan_t     cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  rcfe_cmd_t    cmd;
  rcfe_status_t status;
  logic         cfg_xfer;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;

  rcfe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_kind_i   (in_data_i.kind),
    .in_mode_i   (in_data_i.fade_mode),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rcfe_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_xfer),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

  // A frame is never written over a result the receiver has not taken.
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!out_valid_o || !out_stall_i))
    else $error("frame written over a pending result");

  // Committing the final frame ends the fade.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.commit && status.frame_last) |=> !status.fading)
    else $error("fade still running after its final frame");

  // A tick outside a fade is dropped without occupying the block.
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_data_i.kind == KindTick) && !status.fading)
    |=> !in_stall_o)
    else $error("idle tick started work");

  // Every committed frame raises the output valid.
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> out_valid_o)
    else $error("committed frame not presented");

endmodule

// ===== tb/rgb_color_fade_engine_tb.sv =====
`timescale 1ns / 100ps

module rgb_color_fade_engine_tb;
  import rcfe_pkg::*;

  localparam int SETTLE     = 20;      // cycles for a start or idle tick to retire
  localparam int LONG_HOLD  = 400;     // one long output hold-off
  localparam int CYCLE_CAP  = 400000;  // hard limit on the run
  localparam int NUM_PHASES = 13;

  // fade_steps for each random phase, extremes included.
  int steps_plan [NUM_PHASES] = '{1, 2, 255, 0, 3, 5, 7, 4, 10, 6, 2, 32, 1};

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      cfg_valid = 1'b0;
  chan_t     cfg_data  = '0;
  logic      cfg_ready;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  rgb_color_fade_engine uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // Items waiting to be sent and frames waiting to come out.
  in_item_t  items_waiting [$];
  out_item_t frames_due [$];

  // Shadow of the fade engine state.
  chan_t  steps_now = StepsReset;
  color_t dom_color = '0;
  color_t fade_from = '0;
  color_t fade_to   = '0;
  chan_t  fade_idx  = '0;
  logic   fading_on = 1'b0;
  logic   keep_target = 1'b0;

  // Idling controls and bookkeeping.
  logic in_gaps_on     = 1'b1;
  logic out_stalls_on  = 1'b1;
  logic long_hold_done = 1'b0;
  int   gap_left   = 0;
  int   stall_left = 0;
  int   n_items    = 0;
  int   n_starts   = 0;
  int   n_frames   = 0;
  int   n_final    = 0;
  int   n_errors   = 0;
  int   n_cycles   = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One channel of a linear crossfade, truncated; the numerator never goes negative.
  function automatic chan_t lerp_chan(chan_t a, chan_t b, chan_t i, chan_t s);
    int unsigned num;
    num = int'(a) * int'(s) + int'(i) * int'(b) - int'(i) * int'(a);
    return chan_t'(num / int'(s));
  endfunction

  // Update the shadow state for one accepted item and queue the frame it causes.
  function automatic void predict_item(in_item_t it);
    color_t    tgt;
    color_t    frame;
    out_item_t res;
    logic      is_last;
    tgt[ChanRed]   = it.target_red;
    tgt[ChanGreen] = it.target_green;
    tgt[ChanBlue]  = it.target_blue;
    if (it.kind == KindStart) begin
      case (it.fade_mode)
        ModeBlend: begin
          fade_from   = dom_color;
          fade_to     = tgt;
          keep_target = 1'b1;
        end
        ModeFadeIn: begin
          fade_from   = '0;
          fade_to     = tgt;
          keep_target = 1'b0;
        end
        ModeFadeOut: begin
          fade_from   = tgt;
          fade_to     = '0;
          keep_target = 1'b0;
        end
        default: return;
      endcase
      fade_idx  = '0;
      fading_on = 1'b1;
      n_starts++;
    end else if (fading_on) begin
      is_last = (fade_idx >= steps_now);
      if (is_last) begin
        frame = fade_to;
      end else begin
        for (int k = 0; k < NumChan; k++) begin
          frame[k] = lerp_chan(fade_from[k], fade_to[k], fade_idx, steps_now);
        end
      end
      res.frame_red   = frame[ChanRed];
      res.frame_green = frame[ChanGreen];
      res.frame_blue  = frame[ChanBlue];
      res.last_frame  = is_last;
      frames_due.push_back(res);
      if (is_last) begin
        fading_on = 1'b0;
        if (keep_target) begin
          dom_color = fade_to;
        end
        keep_target = 1'b0;
        fade_idx    = '0;
      end else begin
        fade_idx = fade_idx + 8'd1;
      end
    end
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("MISMATCH at frame %0d, %s: got %0h, expected %0h", n_frames, what, got, want);
    n_errors++;
  endtask

  // Input driver: presents queued items, with a drawn gap after each transfer.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_item(in_data);
        n_items++;
        gap_left = in_gaps_on ? $urandom_range(0, 16) : 0;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (items_waiting.size() != 0) begin
          in_data  <= items_waiting.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each frame transfer and draws the stall before the next.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (frames_due.size() == 0) begin
          report_mismatch("frame with nothing expected", 32'(out_data), 0);
        end else begin
          out_item_t want;
          want = frames_due.pop_front();
          if (out_data.frame_red !== want.frame_red)
            report_mismatch("red", out_data.frame_red, want.frame_red);
          if (out_data.frame_green !== want.frame_green)
            report_mismatch("green", out_data.frame_green, want.frame_green);
          if (out_data.frame_blue !== want.frame_blue)
            report_mismatch("blue", out_data.frame_blue, want.frame_blue);
          if (out_data.last_frame !== want.last_frame)
            report_mismatch("last flag", out_data.last_frame, want.last_frame);
        end
        n_frames++;
        if (out_data.last_frame) begin
          n_final++;
        end
        stall_left = out_stalls_on ? $urandom_range(0, 16) : 0;
      end
      // Once, hold the output off for a long stretch while items keep coming.
      if (!long_hold_done && n_frames >= 250 && items_waiting.size() > 30) begin
        stall_left     = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_CAP) begin
      $display("Timeout after %0d cycles, %0d frames still expected", n_cycles,
               frames_due.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic void queue_item(logic kind, logic [1:0] mode, chan_t r, chan_t g,
                                     chan_t b);
    in_item_t it;
    it.kind         = kind;
    it.fade_mode    = mode;
    it.target_red   = r;
    it.target_green = g;
    it.target_blue  = b;
    items_waiting.push_back(it);
  endfunction

  // Channel value that lands on the extremes fairly often.
  function automatic chan_t pick_chan();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return chan_t'($urandom_range(0, 255));
    endcase
  endfunction

  // One fade sequence: mostly a start and a full run of ticks, sometimes a
  // cut-short fade, now and then a burst of unstructured items.
  task automatic queue_fade(input int s, inout int added);
    int         pick;
    int         n;
    logic [1:0] mode;
    pick = $urandom_range(0, 9);
    if (pick == 9) begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        queue_item(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), pick_chan(),
                   pick_chan(), pick_chan());
      end
      added += n;
      return;
    end
    n    = (pick < 7) ? s + 1 + $urandom_range(0, 2) : $urandom_range(0, s);
    mode = ($urandom_range(0, 19) == 0) ? ModeUnused : 2'($urandom_range(0, 2));
    queue_item(KindStart, mode, pick_chan(), pick_chan(), pick_chan());
    repeat (n) begin
      queue_item(KindTick, 2'($urandom_range(0, 3)), chan_t'($urandom_range(0, 255)),
                 chan_t'($urandom_range(0, 255)), chan_t'($urandom_range(0, 255)));
    end
    added += n + 1;
  endtask

  // Wait until every item is sent and every frame has come out, then let the
  // block finish any start or idle tick still in flight.
  task automatic wait_drained();
    while (items_waiting.size() != 0 || in_valid || frames_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_steps(input chan_t v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    steps_now = v;
  endtask

  initial begin
    int added;
    int budget;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset step count: idle ticks, the unused mode,
    // every mode, and restarts of a fade in progress.
    queue_item(KindTick, ModeBlend, 8'h00, 8'h00, 8'h00);
    queue_item(KindStart, ModeUnused, 8'hff, 8'hff, 8'hff);
    queue_item(KindTick, ModeUnused, 8'hff, 8'hff, 8'hff);
    queue_item(KindStart, ModeBlend, 8'hff, 8'hff, 8'hff);
    repeat (3) queue_item(KindTick, ModeBlend, 8'h00, 8'h00, 8'h00);
    queue_item(KindStart, ModeFadeIn, 8'h00, 8'hff, 8'h80);
    repeat (2) queue_item(KindTick, ModeFadeIn, 8'h00, 8'h00, 8'h00);
    queue_item(KindStart, ModeFadeOut, 8'hff, 8'h00, 8'hff);
    repeat (2) queue_item(KindTick, ModeFadeOut, 8'h00, 8'h00, 8'h00);
    wait_drained();

    // Lower the step count under the fade in progress, then fade with zero steps.
    write_steps(8'd0);
    queue_item(KindTick, ModeBlend, 8'h00, 8'h00, 8'h00);
    queue_item(KindTick, ModeBlend, 8'h00, 8'h00, 8'h00);
    queue_item(KindStart, ModeBlend, 8'h12, 8'h34, 8'h56);
    queue_item(KindTick, ModeBlend, 8'h00, 8'h00, 8'h00);
    queue_item(KindStart, ModeBlend, 8'hff, 8'h00, 8'h7f);
    queue_item(KindTick, ModeBlend, 8'h00, 8'h00, 8'h00);
    queue_item(KindStart, ModeFadeIn, 8'haa, 8'h55, 8'h01);
    queue_item(KindTick, ModeBlend, 8'h00, 8'h00, 8'h00);
    wait_drained();

    // Random phases, one step count each, with the idling pattern varied.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_steps(chan_t'(steps_plan[p]));
      in_gaps_on    = (p % 3 != 1);
      out_stalls_on = (p % 3 != 2);
      budget = (steps_plan[p] == 255) ? 200 : 100;
      added  = 0;
      while (added < budget) begin
        queue_fade(steps_plan[p], added);
      end
      wait_drained();
    end

    $display("Sent %0d items, %0d of them fade starts; checked %0d frames, %0d final.",
             n_items, n_starts, n_frames, n_final);
    $display("Step counts ran from 0 to 255 with random gaps, stalls and one long hold-off.");
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
